// ===== hdl/pl_pkg.sv =====
// package for the positional list block: opcodes, status codes, states
// and the command word that the control hands to every list cell
// no dependencies
`default_nettype none

package pl_pkg;

  // request opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOCATE = 2'd2;

  // response status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  // width of the value field and of the position fields
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 5;

  // control state
  typedef enum logic [0:0] {
    PL_IDLE,
    PL_SCAN
  } pl_state_t;

  // command broadcast to every cell at once
  typedef struct packed {
    logic               ins;    // insert at pos0, shift later entries up
    logic               del;    // delete at pos0, shift later entries down
    logic               loc;    // capture match flags against value
    logic               scan;   // shift match flags toward cell zero
    logic [VALUE_W-1:0] value;
  } pl_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/pl_cell.sv =====
// one cell of the list chain: holds one entry and one match flag
// depends on pl_pkg for the command word
`default_nettype none

module pl_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned PW    = 5
) (
  input  wire logic                           clk,
  input  wire pl_pkg::pl_cmd_t                cmd,
  input  wire logic [PW-1:0]                  pos0,
  input  wire logic [PW-1:0]                  cnt,
  input  wire logic [pl_pkg::VALUE_W-1:0]     left_data,
  input  wire logic [pl_pkg::VALUE_W-1:0]     right_data,
  input  wire logic                           right_match,
  output logic      [pl_pkg::VALUE_W-1:0]     data,
  output logic                                match
);

  localparam logic [PW-1:0] MY_POS = PW'(INDEX);

  // entry: load, take from left on insert, take from right on delete
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (MY_POS == pos0) begin
        data <= cmd.value;
      end else if (MY_POS > pos0) begin
        data <= left_data;
      end
    end else if (cmd.del) begin
      if (MY_POS >= pos0) begin
        data <= right_data;
      end
    end
  end

  // match flag: capture on locate, then shift toward cell zero
  always_ff @(posedge clk) begin
    if (cmd.loc) begin
      match <= (data == cmd.value) && (MY_POS < cnt);
    end else if (cmd.scan) begin
      match <= right_match;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/positional_list_insert_delete_search.sv =====
// Positional list of up to CAPACITY signed 32-bit entries with insert,
// delete and locate requests.
//
// Request channel: req_valid/req_stall carry opcode, position and value.
// Response channel: rsp_valid/rsp_stall carry status, removed_value,
// found_position and entry_count. Each request gives exactly one response.
//
// Insert and delete are done in the accept cycle by the cell chain: every
// cell from the position on loads, takes its left neighbor's entry or its
// right neighbor's entry at once. Their response is registered and shows in
// the cycle after accept, and a new request is taken every cycle while the
// response side drains. Locate captures a match flag in every cell, then
// shifts the flags toward cell zero one position per cycle; no request is
// taken during the scan.
//
// Reset clears the count and the control; entries hold no reset value.
// While the response is stalled the response register holds its word and
// req_stall stays high until it is taken.
// depends on pl_pkg and pl_cell
`default_nettype none

module positional_list_insert_delete_search #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_stall,
  input  wire logic [1:0]                        opcode,
  input  wire logic [pl_pkg::POS_W-1:0]          position,
  input  wire logic signed [pl_pkg::VALUE_W-1:0] value,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_stall,
  output logic      [1:0]                        status,
  output logic signed [pl_pkg::VALUE_W-1:0]      removed_value,
  output logic      [pl_pkg::POS_W-1:0]          found_position,
  output logic      [pl_pkg::POS_W-1:0]          entry_count
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > pl_pkg::POS_W) ? CW : pl_pkg::POS_W;
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  pl_pkg::pl_state_t state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] scan_idx;

  logic [pl_pkg::VALUE_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]        cell_match;
  pl_pkg::pl_cmd_t            cmd;

  logic          req_accept;
  logic          is_ins, is_del, is_loc;
  logic [PW-1:0] pos_ext, pos0, cnt_ext;
  logic          pos_zero, ins_range, ins_full, ins_ok, del_range, del_ok;
  logic          scan_hit, scan_last, scan_done;
  logic [1:0]    direct_status;
  logic [CW-1:0] scan_pos;

  // request decode and range checks
  assign req_accept = req_valid && !req_stall;
  assign is_ins     = (opcode == pl_pkg::OP_INSERT);
  assign is_del     = (opcode == pl_pkg::OP_DELETE);
  assign is_loc     = (opcode == pl_pkg::OP_LOCATE);
  assign pos_ext    = PW'(position);
  assign cnt_ext    = PW'(count);
  assign pos0       = pos_ext - PW'(1);
  assign pos_zero   = (position == '0);
  assign ins_range  = pos_zero || (pos0 > cnt_ext);
  assign ins_full   = (count == CW'(CAPACITY));
  assign ins_ok     = is_ins && !ins_range && !ins_full;
  assign del_range  = pos_zero || (pos0 >= cnt_ext);
  assign del_ok     = is_del && !del_range;

  // status for insert, delete and unused opcodes
  always_comb begin
    if (is_ins) begin
      direct_status = ins_range ? pl_pkg::ST_RANGE :
                      (ins_full ? pl_pkg::ST_FULL : pl_pkg::ST_OK);
    end else if (is_del) begin
      direct_status = del_range ? pl_pkg::ST_RANGE : pl_pkg::ST_OK;
    end else begin
      direct_status = pl_pkg::ST_RANGE;
    end
  end

  // count after the request
  always_comb begin
    count_next = count;
    if (req_accept && ins_ok) begin
      count_next = count + CW'(1);
    end else if (req_accept && del_ok) begin
      count_next = count - CW'(1);
    end
  end

  // command word for the chain
  always_comb begin
    cmd.ins   = req_accept && ins_ok;
    cmd.del   = req_accept && del_ok;
    cmd.loc   = req_accept && is_loc;
    cmd.scan  = (state == pl_pkg::PL_SCAN);
    cmd.value = value;
  end

  // the cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [pl_pkg::VALUE_W-1:0] left_d, right_d;
    logic                       right_m;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
      assign right_m = 1'b0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
      assign right_m = cell_match[i+1];
    end
    pl_cell #(
      .INDEX (i),
      .PW    (PW)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .pos0        (pos0),
      .cnt         (cnt_ext),
      .left_data   (left_d),
      .right_data  (right_d),
      .right_match (right_m),
      .data        (cell_data[i]),
      .match       (cell_match[i])
    );
  end

  // scan progress: the head flag belongs to position scan_idx+1
  assign scan_pos  = scan_idx + CW'(1);
  assign scan_hit  = cell_match[0];
  assign scan_last = (scan_pos >= count);
  assign scan_done = (state == pl_pkg::PL_SCAN) && (scan_hit || scan_last);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pl_pkg::PL_IDLE: begin
        if (req_accept && is_loc) begin
          state_next = pl_pkg::PL_SCAN;
        end
      end
      pl_pkg::PL_SCAN: begin
        if (scan_done) begin
          state_next = pl_pkg::PL_IDLE;
        end
      end
      default: state_next = pl_pkg::PL_IDLE;
    endcase
  end

  // request side stall
  always_comb begin
    unique case (state)
      pl_pkg::PL_IDLE: req_stall = rsp_valid && rsp_stall;
      pl_pkg::PL_SCAN: req_stall = 1'b1;
      default:         req_stall = 1'b1;
    endcase
  end

  // state, count and scan index
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pl_pkg::PL_IDLE;
      count    <= '0;
      scan_idx <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (req_accept) begin
        scan_idx <= '0;
      end else if (state == pl_pkg::PL_SCAN) begin
        scan_idx <= scan_pos;
      end
    end
  end

  // response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((req_accept && !is_loc) || scan_done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // response word
  always_ff @(posedge clk) begin
    if (req_accept && !is_loc) begin
      status         <= direct_status;
      removed_value  <= del_ok ? cell_data[pos0[IW-1:0]] : '0;
      found_position <= '0;
      entry_count    <= pl_pkg::POS_W'(count_next);
    end else if (scan_done) begin
      status         <= scan_hit ? pl_pkg::ST_OK : pl_pkg::ST_MISS;
      removed_value  <= '0;
      found_position <= scan_hit ? pl_pkg::POS_W'(scan_pos) : '0;
      entry_count    <= pl_pkg::POS_W'(count);
    end
  end

  // count stays within capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("count exceeds capacity");

  // a successful insert grows the list by one
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    req_accept && ins_ok |=> count == $past(count) + CW'(1))
    else $error("insert did not grow count");

  // a successful delete shrinks the list by one
  a_delete_count: assert property (@(posedge clk) disable iff (rst)
    req_accept && del_ok |=> count == $past(count) - CW'(1))
    else $error("delete did not shrink count");

  // no request is taken during a scan
  a_scan_stall: assert property (@(posedge clk) disable iff (rst)
    state == pl_pkg::PL_SCAN |-> req_stall)
    else $error("request accepted during scan");

  // a new response word comes only from an accept or a finished scan
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past((req_accept && !is_loc) || scan_done))
    else $error("response without a source");

endmodule

`default_nettype wire
